>>> rtl/qslerp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, the angle table and the sideband record for the quaternion slerp pipeline.
// No dependencies.
package qslerp_pkg;

  localparam int FRAC_BITS         = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CW                = 34;  // CORDIC datapath and angle width, Q30
  localparam int QW                = 45;  // weight quotient bits
  localparam int WW                = 46;  // signed weight width
  localparam int SW                = 48;  // signed q1 scale width

  localparam logic [7:0] TOL_RESET = 8'd1;

  localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [QW-1:0]        W_LIMIT     = {1'b1, {(QW-1){1'b0}}};

  localparam logic signed [CW-1:0] ATAN_Q30 [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
    34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024, 34'sd512, 34'sd256,
    34'sd128, 34'sd64, 34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2, 34'sd1, 34'sd0
  };

  typedef struct packed {
    logic                   pass;
    logic                   neg;
    logic                   flip;
    logic                   sneg;
    logic                   ovf;
    logic [3:0][15:0]       q1;
    logic [3:0][15:0]       q2;
    logic [16:0]            t;
    logic signed [31:0]     d;
    logic [30:0]            s;
    logic signed [CW-1:0]   c;
  } side_t;

endpackage

>>> rtl/qslerp_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the quaternion slerp unit.
// No dependencies.
interface qslerp_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q1_w;
  logic signed [15:0] q1_x;
  logic signed [15:0] q1_y;
  logic signed [15:0] q1_z;
  logic signed [15:0] q2_w;
  logic signed [15:0] q2_x;
  logic signed [15:0] q2_y;
  logic signed [15:0] q2_z;
  logic [16:0]        blend;

  modport source (output valid, q1_w, q1_x, q1_y, q1_z, q2_w, q2_x, q2_y, q2_z, blend,
                  input ready);
  modport sink (input valid, q1_w, q1_x, q1_y, q1_z, q2_w, q2_x, q2_y, q2_z, blend,
                output ready);
endinterface

interface qslerp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_w;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               passed_through;

  modport source (output valid, out_w, out_x, out_y, out_z, passed_through, input ready);
  modport sink (input valid, out_w, out_x, out_y, out_z, passed_through, output ready);
endinterface

>>> rtl/qslerp_front.sv
`timescale 1ns / 1ps
// Front end: dot product, clamp, near-one test and 1 - dot^2 radicand, three stages.
// Depends on qslerp_pkg.
module qslerp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [3:0][15:0]  q1_i,
  input  logic [3:0][15:0]  q2_i,
  input  logic [16:0]       blend_i,
  input  logic [7:0]        tol_i,
  output logic              valid_o,
  output qslerp_pkg::side_t side_o,
  output logic [60:0]       rad_o
);
  import qslerp_pkg::*;

  localparam logic [16:0]        T_ONE = 17'd65536;
  localparam logic signed [33:0] ONE2  = 34'sd1 <<< (2 * FRAC_BITS);

  logic               v1_q, v2_q, v3_q;
  logic signed [31:0] prod_q [4];
  side_t              s1_q, s2_q, s3_q;
  side_t              s1_d, s2_d;
  logic [30:0]        mag_q;
  logic [60:0]        rad_q;

  logic signed [33:0] dot, dot_c, tol, absd;
  logic [30:0]        mag;
  logic [61:0]        sq;

  always_comb begin
    s1_d    = '0;
    s1_d.q1 = q1_i;
    s1_d.q2 = q2_i;
    s1_d.t  = (blend_i > T_ONE) ? T_ONE : blend_i;
  end

  always_comb begin
    dot = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
    if (dot > ONE2) begin
      dot_c = ONE2;
    end else if (dot < -ONE2) begin
      dot_c = -ONE2;
    end else begin
      dot_c = dot;
    end
    tol       = 34'(tol_i) <<< FRAC_BITS;
    s2_d      = s1_q;
    s2_d.pass = ((ONE2 - dot_c) <= tol) || ((dot_c + ONE2) <= tol);
    s2_d.neg  = dot_c < 0;
    absd      = s2_d.neg ? -dot_c : dot_c;
    mag       = 31'(absd <<< (30 - 2 * FRAC_BITS));
    s2_d.d    = s2_d.neg ? -$signed(32'(mag)) : $signed(32'(mag));
  end

  assign sq = mag_q * mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= $signed(q1_i[i]) * $signed(q2_i[i]);
      end
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      mag_q <= mag;
      s3_q  <= s2_q;
      rad_q <= 61'((62'd1 << 60) - sq);
    end
  end

  assign valid_o = v3_q;
  assign side_o  = s3_q;
  assign rad_o   = rad_q;

endmodule

>>> rtl/qslerp_sqrt_step.sv
`timescale 1ns / 1ps
// One result bit of the restoring square root of the radicand, registered.
// Depends on qslerp_pkg.
module qslerp_sqrt_step #(
  parameter int BIT = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [60:0]       rad_i,
  input  logic [30:0]       root_i,
  input  qslerp_pkg::side_t side_i,
  output logic              valid_o,
  output logic [60:0]       rad_o,
  output logic [30:0]       root_o,
  output qslerp_pkg::side_t side_o
);
  import qslerp_pkg::*;

  logic        valid_q;
  logic [60:0] rad_q;
  logic [30:0] root_q;
  side_t       side_q;
  logic [62:0] trial;
  logic        ge;

  assign trial = (63'(root_i) << (BIT + 1)) + (63'd1 << (2 * BIT));
  assign ge    = 63'(rad_i) >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= ge ? 61'(63'(rad_i) - trial) : rad_i;
      root_q <= ge ? (root_i | (31'd1 << BIT)) : root_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

>>> rtl/qslerp_cordic_step.sv
`timescale 1ns / 1ps
// One CORDIC micro-rotation, vectoring or rotation mode, registered.
// Depends on qslerp_pkg.
module qslerp_cordic_step #(
  parameter int   IDX    = 0,
  parameter logic VECTOR = 1'b1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [qslerp_pkg::CW-1:0] x_i,
  input  logic signed [qslerp_pkg::CW-1:0] y_i,
  input  logic signed [qslerp_pkg::CW-1:0] z_i,
  input  qslerp_pkg::side_t             side_i,
  output logic                          valid_o,
  output logic signed [qslerp_pkg::CW-1:0] x_o,
  output logic signed [qslerp_pkg::CW-1:0] y_o,
  output logic signed [qslerp_pkg::CW-1:0] z_o,
  output qslerp_pkg::side_t             side_o
);
  import qslerp_pkg::*;

  localparam int AI = IDX % 32;

  logic                 valid_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [CW-1:0] x_d, y_d, z_d, xs, ys;
  side_t                side_q;
  logic                 up;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (VECTOR) begin
      up  = y_i > 0;
      x_d = up ? x_i + ys : x_i - ys;
      y_d = up ? y_i - xs : y_i + xs;
      z_d = up ? z_i + ATAN_Q30[AI] : z_i - ATAN_Q30[AI];
    end else begin
      up  = z_i >= 0;
      x_d = up ? x_i - ys : x_i + ys;
      y_d = up ? y_i + xs : y_i - xs;
      z_d = up ? z_i - ATAN_Q30[AI] : z_i + ATAN_Q30[AI];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

>>> rtl/qslerp_div_step.sv
`timescale 1ns / 1ps
// One quotient bit of the restoring divide sin / denom, registered.
// Depends on qslerp_pkg.
module qslerp_div_step #(
  parameter int BIT = 44
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [62:0]               rem_i,
  input  logic [qslerp_pkg::QW-1:0] quo_i,
  input  qslerp_pkg::side_t         side_i,
  output logic                      valid_o,
  output logic [62:0]               rem_o,
  output logic [qslerp_pkg::QW-1:0] quo_o,
  output qslerp_pkg::side_t         side_o
);
  import qslerp_pkg::*;

  logic          valid_q;
  logic [62:0]   rem_q;
  logic [QW-1:0] quo_q;
  side_t         side_q;
  logic [76:0]   den;
  logic          ge;

  assign den = 77'(side_i.s) << BIT;
  assign ge  = 77'(rem_i) >= den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge ? 63'(77'(rem_i) - den) : rem_i;
      quo_q  <= ge ? (quo_i | (QW'(1) << BIT)) : quo_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

>>> rtl/qslerp_back.sv
`timescale 1ns / 1ps
// Back end: weight clamp, q1 scale, component blend, rounding, saturation or pass-through, and output register.
// Depends on qslerp_pkg.
module qslerp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [qslerp_pkg::QW-1:0] quo_i,
  input  qslerp_pkg::side_t         side_i,
  output logic                      valid_o,
  output logic [3:0][15:0]          res_o,
  output logic                      pass_o
);
  import qslerp_pkg::*;

  logic                 vw_q, vm1_q, vm2_q, vp_q, vo_q;
  side_t                sw_q, sm1_q, sm2_q, sp_q;
  logic signed [WW-1:0] w_q, wm1_q, wm2_q;
  logic signed [61:0]   ph_q;
  logic signed [48:0]   pl_q;
  logic signed [SW-1:0] scale_q;
  logic signed [63:0]   p1_q [4];
  logic signed [63:0]   p2_q [4];
  logic [3:0][15:0]     res_q;
  logic                 pass_q;

  logic [QW-1:0]        wm;
  logic signed [WW-1:0] w_d;
  logic signed [29:0]   wh;
  logic signed [78:0]   mq;
  logic signed [65:0]   acc, rnd;
  logic [3:0][15:0]     res_d;

  always_comb begin
    wm  = (side_i.ovf || quo_i > W_LIMIT) ? W_LIMIT : quo_i;
    w_d = side_i.sneg ? -$signed(WW'(wm)) : $signed(WW'(wm));
    wh  = 30'(w_q >>> 16);
    mq  = ((79'(ph_q) <<< 16) + 79'(pl_q) + 79'sd536870912) >>> 30;
  end

  always_comb begin
    res_d = '0;
    for (int i = 0; i < 4; i++) begin
      acc = 66'(p1_q[i]) + 66'(p2_q[i]) + 66'sd536870912;
      rnd = acc >>> 30;
      if (sp_q.pass) begin
        res_d[i] = sp_q.q1[i];
      end else if (rnd > 66'sd32767) begin
        res_d[i] = 16'h7fff;
      end else if (rnd < -66'sd32768) begin
        res_d[i] = 16'h8000;
      end else begin
        res_d[i] = rnd[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q  <= 1'b0;
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      vp_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else if (en_i) begin
      vw_q  <= valid_i;
      vm1_q <= vw_q;
      vm2_q <= vm1_q;
      vp_q  <= vm2_q;
      vo_q  <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q     <= w_d;
      sw_q    <= side_i;
      ph_q    <= sw_q.d * wh;
      pl_q    <= sw_q.d * $signed({1'b0, w_q[15:0]});
      wm1_q   <= w_q;
      sm1_q   <= sw_q;
      scale_q <= SW'(sm1_q.c) - SW'(mq);
      wm2_q   <= wm1_q;
      sm2_q   <= sm1_q;
      for (int i = 0; i < 4; i++) begin
        p1_q[i] <= $signed(sm2_q.q1[i]) * scale_q;
        p2_q[i] <= $signed(sm2_q.q2[i]) * wm2_q;
      end
      sp_q    <= sm2_q;
      res_q   <= res_d;
      pass_q  <= sp_q.pass;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;
  assign pass_o  = pass_q;

endmodule

>>> rtl/quaternion_slerp_unit.sv
`timescale 1ns / 1ps
// Quaternion slerp unit: throughput one request per cycle while the response is not stalled, set
// by the bit-per-stage root, CORDIC and divide. A stalled response holds the whole pipeline.
// Async active-low reset empties the pipeline and sets the tolerance register tol_q to 1.
// Depends on qslerp_pkg, qslerp_if and the qslerp_* stage modules.
module quaternion_slerp_unit #(
  parameter int CORDIC_STAGES = qslerp_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  qslerp_req_if.sink  req_i,
  qslerp_rsp_if.source rsp_o
);
  import qslerp_pkg::*;

  localparam int RB = 31;  // root bits
  localparam int DB = QW;  // divide steps

  logic       en;
  logic [7:0] tol_q;

  logic        fv;
  side_t       fs;
  logic [60:0] frad;

  logic        rv   [RB+1];
  logic [60:0] rrad [RB+1];
  logic [30:0] rrt  [RB+1];
  side_t       rs   [RB+1];

  logic                 vv [CORDIC_STAGES+1];
  logic signed [CW-1:0] vx [CORDIC_STAGES+1];
  logic signed [CW-1:0] vy [CORDIC_STAGES+1];
  logic signed [CW-1:0] vz [CORDIC_STAGES+1];
  side_t                vs [CORDIC_STAGES+1];

  logic                 ov [CORDIC_STAGES+1];
  logic signed [CW-1:0] ox [CORDIC_STAGES+1];
  logic signed [CW-1:0] oy [CORDIC_STAGES+1];
  logic signed [CW-1:0] oz [CORDIC_STAGES+1];
  side_t                os [CORDIC_STAGES+1];

  logic          dv   [DB+1];
  logic [62:0]   drem [DB+1];
  logic [QW-1:0] dq   [DB+1];
  side_t         ds   [DB+1];

  side_t                sq_side;
  logic                 t_v_q, f_v_q;
  side_t                t_s_q, f_s_q, f_s_d, e_s_d;
  logic signed [CW-1:0] t_a_q, f_a_q, theta, f_a_d;
  logic signed [51:0]   tprod;
  logic signed [CW-1:0] cc, absn;
  logic [62:0]          num;

  logic             out_valid;
  logic [3:0][15:0] res;
  logic             pass;

  assign en          = !out_valid || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  qslerp_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req_i.valid),
    .q1_i({req_i.q1_z, req_i.q1_y, req_i.q1_x, req_i.q1_w}),
    .q2_i({req_i.q2_z, req_i.q2_y, req_i.q2_x, req_i.q2_w}),
    .blend_i(req_i.blend), .tol_i(tol_q),
    .valid_o(fv), .side_o(fs), .rad_o(frad)
  );

  assign rv[0]   = fv;
  assign rrad[0] = frad;
  assign rrt[0]  = '0;
  assign rs[0]   = fs;

  for (genvar k = 0; k < RB; k++) begin : g_root
    qslerp_sqrt_step #(.BIT(RB - 1 - k)) u_step (
      .clk_i, .rst_ni, .en_i(en), .valid_i(rv[k]), .rad_i(rrad[k]), .root_i(rrt[k]),
      .side_i(rs[k]), .valid_o(rv[k+1]), .rad_o(rrad[k+1]), .root_o(rrt[k+1]),
      .side_o(rs[k+1])
    );
  end

  always_comb begin
    sq_side      = rs[RB];
    sq_side.s    = rrt[RB];
    sq_side.pass = rs[RB].pass || (rrt[RB] == '0);
  end

  assign vv[0] = rv[RB];
  assign vx[0] = sq_side.neg ? -CW'(sq_side.d) : CW'(sq_side.d);
  assign vy[0] = CW'(rrt[RB]);
  assign vz[0] = '0;
  assign vs[0] = sq_side;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    qslerp_cordic_step #(.IDX(k), .VECTOR(1'b1)) u_step (
      .clk_i, .rst_ni, .en_i(en), .valid_i(vv[k]), .x_i(vx[k]), .y_i(vy[k]), .z_i(vz[k]),
      .side_i(vs[k]), .valid_o(vv[k+1]), .x_o(vx[k+1]), .y_o(vy[k+1]), .z_o(vz[k+1]),
      .side_o(vs[k+1])
    );
  end

  // angle scale by t, then fold into the first quadrant
  always_comb begin
    theta      = vs[CORDIC_STAGES].neg ? Q30_PI - vz[CORDIC_STAGES] : vz[CORDIC_STAGES];
    tprod      = $signed({1'b0, vs[CORDIC_STAGES].t}) * theta;
    f_s_d      = t_s_q;
    f_s_d.flip = t_a_q > Q30_HALF_PI;
    f_a_d      = f_s_d.flip ? Q30_PI - t_a_q : t_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else if (en) begin
      t_v_q <= vv[CORDIC_STAGES];
      f_v_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_a_q <= CW'((tprod + 52'sd32768) >>> 16);
      t_s_q <= vs[CORDIC_STAGES];
      f_a_q <= f_a_d;
      f_s_q <= f_s_d;
    end
  end

  assign ov[0] = f_v_q;
  assign ox[0] = CORDIC_GAIN;
  assign oy[0] = '0;
  assign oz[0] = f_a_q;
  assign os[0] = f_s_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    qslerp_cordic_step #(.IDX(k), .VECTOR(1'b0)) u_step (
      .clk_i, .rst_ni, .en_i(en), .valid_i(ov[k]), .x_i(ox[k]), .y_i(oy[k]), .z_i(oz[k]),
      .side_i(os[k]), .valid_o(ov[k+1]), .x_o(ox[k+1]), .y_o(oy[k+1]), .z_o(oz[k+1]),
      .side_o(os[k+1])
    );
  end

  // divide entry: rounded numerator and overflow of the 45-bit quotient (2^45)
  always_comb begin
    e_s_d      = os[CORDIC_STAGES];
    cc         = e_s_d.flip ? -ox[CORDIC_STAGES] : ox[CORDIC_STAGES];
    e_s_d.c    = cc;
    e_s_d.sneg = oy[CORDIC_STAGES] < 0;
    absn       = e_s_d.sneg ? -oy[CORDIC_STAGES] : oy[CORDIC_STAGES];
    num        = (63'(absn) << 30) + 63'(e_s_d.s >> 1);
    e_s_d.ovf  = (num >> QW) >= 63'(e_s_d.s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= ov[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem[0] <= num;
      ds[0]   <= e_s_d;
    end
  end

  assign dq[0] = '0;

  for (genvar k = 0; k < DB; k++) begin : g_div
    qslerp_div_step #(.BIT(DB - 1 - k)) u_step (
      .clk_i, .rst_ni, .en_i(en), .valid_i(dv[k]), .rem_i(drem[k]), .quo_i(dq[k]),
      .side_i(ds[k]), .valid_o(dv[k+1]), .rem_o(drem[k+1]), .quo_o(dq[k+1]),
      .side_o(ds[k+1])
    );
  end

  qslerp_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv[DB]), .quo_i(dq[DB]), .side_i(ds[DB]),
    .valid_o(out_valid), .res_o(res), .pass_o(pass)
  );

  assign rsp_o.valid          = out_valid;
  assign rsp_o.out_w          = res[0];
  assign rsp_o.out_x          = res[1];
  assign rsp_o.out_y          = res[2];
  assign rsp_o.out_z          = res[3];
  assign rsp_o.passed_through = pass;

endmodule

>>> rtl/qslerp_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the quaternion slerp unit, bound to the top level.
// Depends on quaternion_slerp_unit.
module qslerp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] out_w_i,
  input logic [15:0] out_x_i,
  input logic [15:0] out_y_i,
  input logic [15:0] out_z_i,
  input logic        pass_i
);

  // request side stalls exactly when a response is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i == (!rsp_valid_i || rsp_ready_i))
    else $error("request ready does not follow response backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(out_w_i) && $stable(out_x_i)
      && $stable(out_y_i) && $stable(out_z_i) && $stable(pass_i))
    else $error("stalled response changed");

  assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("response valid during reset");

  // handshake controls stay known out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({req_valid_i, req_ready_i, rsp_valid_i, rsp_ready_i}))
    else $error("handshake signal unknown");

endmodule

bind quaternion_slerp_unit qslerp_checker u_qslerp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .out_w_i     (rsp_o.out_w),
  .out_x_i     (rsp_o.out_x),
  .out_y_i     (rsp_o.out_y),
  .out_z_i     (rsp_o.out_z),
  .pass_i      (rsp_o.passed_through)
);
